// ===== hw/rtl/pidslew_pkg.sv =====
// shared types, register indexes and the 32-bit saturation helper
// for the pid controller with slew limiting; no dependencies
`default_nettype none

package pidslew_pkg;

    localparam int POSITION_WIDTH_DEF    = 16;
    localparam int INTEGRAL_DEADBAND_DEF = 5;
    localparam int GAIN_W                = 16;
    localparam int CFG_W                 = 16;
    localparam int CFG_IDX_W             = 3;
    localparam int POWER_W               = 32;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN          = 3'd0,
        REG_KI_GAIN          = 3'd1,
        REG_KD_GAIN          = 3'd2,
        REG_SLEW_STEP        = 3'd3,
        REG_SLEW_ENABLE      = 3'd4,
        REG_ACCEL_LIMIT      = 3'd5,
        REG_INTEGRAL_WINDOW  = 3'd6,
        REG_SETTLE_TOLERANCE = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] ki_gain;
        logic [GAIN_W-1:0] kd_gain;
        logic [CFG_W-1:0]  slew_step;
        logic              slew_enable;
        logic [CFG_W-1:0]  accel_limit;
        logic [CFG_W-1:0]  integral_window;
        logic [CFG_W-1:0]  settle_tolerance;
    } cfg_t;

    // control bits that travel with an item down the pipe
    typedef struct packed {
        logic slew_sel;
        logic settled;
    } stage_ctl_t;

    function automatic logic signed [POWER_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [POWER_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = POWER_W'(SAT_MAX);
        end
        else if (v < SAT_MIN)
        begin
            r = POWER_W'(SAT_MIN);
        end
        else
        begin
            r = POWER_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pidslew_if.sv =====
// valid/ready channel interfaces: position samples, drive results, register writes
// depends on pidslew_pkg
`default_nettype none

interface pidslew_in_if #(
    parameter int PW = pidslew_pkg::POSITION_WIDTH_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic signed [PW-1:0] target_position;
    logic signed [PW-1:0] measured_position;

    modport source (output valid, output target_position, output measured_position,
                    input ready);
    modport sink   (input valid, input target_position, input measured_position,
                    output ready);
endinterface

interface pidslew_out_if ();
    logic                                      valid;
    logic                                      ready;
    logic signed [pidslew_pkg::POWER_W-1:0]    drive_power;
    logic                                      is_settled;

    modport source (output valid, output drive_power, output is_settled, input ready);
    modport sink   (input valid, input drive_power, input is_settled, output ready);
endinterface

interface pidslew_cfg_if ();
    logic                              valid;
    logic                              ready;
    logic [pidslew_pkg::CFG_IDX_W-1:0] index;
    logic [pidslew_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pid_controller_with_slew.sv =====
// top level of the position pid controller with slew limiting
// depends on pidslew_pkg, pidslew_if, pidslew_cfg, pidslew_err, pidslew_mul, pidslew_out
//
// usage
//   sample : valid/ready channel carrying target_position and measured_position
//   result : valid/ready channel carrying drive_power (q24.8, saturated) and is_settled
//   cfg    : register write channel (index, data), always ready; write gains and
//            limits only while no sample is in flight
// pipeline
//   input register -> error/integral/derivative stage -> gain multiply stage
//   -> output register; one sample per cycle sustained while result.ready is high, so a new
//   transfer can be taken every clock while earlier samples are still in the pipe
//   the integral, previous error, settled flag and power feedback are updated as
//   each sample passes its stage, so back to back samples see the right history
// stalls
//   when result.ready is low the output register holds; bubbles ahead of it are
//   squeezed out and sample.ready drops once every stage is full
// reset
//   rst_n clears the valid flags, the integral, previous error, power and settled
//   flag to zero; no clearing pass is needed
`default_nettype none

module pid_controller_with_slew #(
    parameter int POSITION_WIDTH    = pidslew_pkg::POSITION_WIDTH_DEF,
    parameter int INTEGRAL_DEADBAND = pidslew_pkg::INTEGRAL_DEADBAND_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pidslew_in_if.sink    sample,
    pidslew_out_if.source result,
    pidslew_cfg_if.sink   cfg
);

    localparam int GW = pidslew_pkg::GAIN_W;

    pidslew_pkg::cfg_t cfg_regs;

    // error stage to multiply stage
    logic                             err_valid;
    logic                             err_ready;
    logic signed [POSITION_WIDTH:0]   stage_err;
    logic signed [31:0]               stage_sum;
    logic signed [POSITION_WIDTH+1:0] stage_delta;
    pidslew_pkg::stage_ctl_t          stage_ctl;

    // multiply stage to output stage
    logic                                term_valid;
    logic                                term_ready;
    logic signed [GW+POSITION_WIDTH:0]   p_term;
    logic signed [GW+31:0]               i_term;
    logic signed [GW+POSITION_WIDTH+1:0] d_term;
    pidslew_pkg::stage_ctl_t             term_ctl;

    // register file, written by index
    pidslew_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg_regs (cfg_regs)
    );

    // input register, error, integral, derivative, settled and slew decision
    pidslew_err #(
        .POSITION_WIDTH    (POSITION_WIDTH),
        .INTEGRAL_DEADBAND (INTEGRAL_DEADBAND)
    ) u_err (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_regs          (cfg_regs),
        .up_valid          (sample.valid),
        .up_ready          (sample.ready),
        .target_position   (sample.target_position),
        .measured_position (sample.measured_position),
        .dn_valid          (err_valid),
        .dn_ready          (err_ready),
        .stage_err         (stage_err),
        .stage_sum         (stage_sum),
        .stage_delta       (stage_delta),
        .stage_ctl         (stage_ctl)
    );

    // three gain multiplies in parallel
    pidslew_mul #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_mul (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_regs    (cfg_regs),
        .up_valid    (err_valid),
        .up_ready    (err_ready),
        .stage_err   (stage_err),
        .stage_sum   (stage_sum),
        .stage_delta (stage_delta),
        .stage_ctl   (stage_ctl),
        .dn_valid    (term_valid),
        .dn_ready    (term_ready),
        .p_term      (p_term),
        .i_term      (i_term),
        .d_term      (d_term),
        .term_ctl    (term_ctl)
    );

    // sum and saturate, or slew from the previous power
    pidslew_out #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_regs    (cfg_regs),
        .up_valid    (term_valid),
        .up_ready    (term_ready),
        .p_term      (p_term),
        .i_term      (i_term),
        .d_term      (d_term),
        .term_ctl    (term_ctl),
        .dn_valid    (result.valid),
        .dn_ready    (result.ready),
        .drive_power (result.drive_power),
        .is_settled  (result.is_settled)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/pidslew_cfg.sv =====
// configuration register file for the pid controller
// depends on pidslew_pkg
`default_nettype none

module pidslew_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_valid,
    output logic                                   wr_ready,
    input  wire logic [pidslew_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [pidslew_pkg::CFG_W-1:0]     wr_data,
    output pidslew_pkg::cfg_t                      cfg_regs
);

    pidslew_pkg::cfg_t cfg_reg;
    pidslew_pkg::cfg_t cfg_next;

    assign wr_ready = 1'b1;
    assign cfg_regs = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            unique case (pidslew_pkg::cfg_idx_t'(wr_index))
                pidslew_pkg::REG_KP_GAIN:          cfg_next.kp_gain          = wr_data;
                pidslew_pkg::REG_KI_GAIN:          cfg_next.ki_gain          = wr_data;
                pidslew_pkg::REG_KD_GAIN:          cfg_next.kd_gain          = wr_data;
                pidslew_pkg::REG_SLEW_STEP:        cfg_next.slew_step        = wr_data;
                pidslew_pkg::REG_SLEW_ENABLE:      cfg_next.slew_enable      = wr_data[0];
                pidslew_pkg::REG_ACCEL_LIMIT:      cfg_next.accel_limit      = wr_data;
                pidslew_pkg::REG_INTEGRAL_WINDOW:  cfg_next.integral_window  = wr_data;
                pidslew_pkg::REG_SETTLE_TOLERANCE: cfg_next.settle_tolerance = wr_data;
                default:                           cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pidslew_err.sv =====
// input register, error / integral / derivative stage and the loop state
// depends on pidslew_pkg
`default_nettype none

module pidslew_err #(
    parameter int POSITION_WIDTH    = pidslew_pkg::POSITION_WIDTH_DEF,
    parameter int INTEGRAL_DEADBAND = pidslew_pkg::INTEGRAL_DEADBAND_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire pidslew_pkg::cfg_t                cfg_regs,
    input  wire logic                             up_valid,
    output logic                                  up_ready,
    input  wire logic signed [POSITION_WIDTH-1:0] target_position,
    input  wire logic signed [POSITION_WIDTH-1:0] measured_position,
    output logic                                  dn_valid,
    input  wire logic                             dn_ready,
    output logic signed [POSITION_WIDTH:0]        stage_err,
    output logic signed [31:0]                    stage_sum,
    output logic signed [POSITION_WIDTH+1:0]      stage_delta,
    output pidslew_pkg::stage_ctl_t               stage_ctl
);

    localparam int EW  = POSITION_WIDTH + 1;
    localparam int DW  = POSITION_WIDTH + 2;
    localparam int MW  = (DW > pidslew_pkg::CFG_W + 1) ? DW : pidslew_pkg::CFG_W + 1;
    localparam int ISW = ((EW > 32) ? EW : 32) + 1;

    // input register
    logic                             in_v_reg;
    logic signed [POSITION_WIDTH-1:0] target_reg;
    logic signed [POSITION_WIDTH-1:0] measured_reg;

    // loop state
    logic signed [31:0]   error_sum_reg;
    logic signed [EW-1:0] last_error_reg;
    logic                 settled_reg;

    // stage register
    logic                    st_v_reg;
    logic signed [EW-1:0]    st_err_reg;
    logic signed [31:0]      st_sum_reg;
    logic signed [DW-1:0]    st_delta_reg;
    pidslew_pkg::stage_ctl_t st_ctl_reg;

    logic                    st_ready;
    logic                    adv;
    logic signed [EW-1:0]    err_val;
    logic [EW-1:0]           err_mag;
    logic                    integ_on;
    logic signed [ISW-1:0]   isum;
    logic signed [31:0]      error_sum_next;
    logic signed [DW-1:0]    delta;
    logic [DW-1:0]           delta_mag;
    logic                    settled_next;
    pidslew_pkg::stage_ctl_t ctl_next;

    assign st_ready = !st_v_reg || dn_ready;
    assign up_ready = !in_v_reg || st_ready;
    assign adv      = in_v_reg && st_ready;

    always_comb
    begin
        err_val  = EW'(target_reg) - EW'(measured_reg);
        err_mag  = err_val[EW-1] ? EW'(-err_val) : EW'(err_val);
        integ_on = (MW'(err_mag) < MW'(cfg_regs.integral_window)) &&
                   (MW'(err_mag) > MW'(INTEGRAL_DEADBAND));
        isum     = ISW'(error_sum_reg) + ISW'(err_val);
        error_sum_next = integ_on ? pidslew_pkg::sat32(64'(isum)) : '0;

        delta     = DW'(err_val) - DW'(last_error_reg);
        delta_mag = delta[DW-1] ? DW'(-delta) : DW'(delta);
        settled_next = settled_reg ||
                       (MW'(delta_mag) < MW'(cfg_regs.settle_tolerance));

        ctl_next.settled  = settled_next;
        ctl_next.slew_sel = cfg_regs.slew_enable &&
                            (MW'(delta_mag) > MW'(cfg_regs.accel_limit));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg       <= 1'b0;
            st_v_reg       <= 1'b0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            settled_reg    <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                in_v_reg <= up_valid;
            end
            if (st_ready)
            begin
                st_v_reg <= in_v_reg;
            end
            if (adv)
            begin
                error_sum_reg  <= error_sum_next;
                last_error_reg <= err_val;
                settled_reg    <= settled_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            target_reg   <= target_position;
            measured_reg <= measured_position;
        end
        if (adv)
        begin
            st_err_reg   <= err_val;
            st_sum_reg   <= error_sum_next;
            st_delta_reg <= delta;
            st_ctl_reg   <= ctl_next;
        end
    end

    assign dn_valid    = st_v_reg;
    assign stage_err   = st_err_reg;
    assign stage_sum   = st_sum_reg;
    assign stage_delta = st_delta_reg;
    assign stage_ctl   = st_ctl_reg;

    // settled is sticky until reset
    a_settled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        settled_reg |=> settled_reg)
        else $error("settled flag dropped");

    // integral clears whenever an item falls outside the window or inside the deadband
    a_integ_clear: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !integ_on |=> error_sum_reg == 32'sd0)
        else $error("integral not cleared outside window");

endmodule

`default_nettype wire

// ===== hw/rtl/pidslew_mul.sv =====
// gain multiply stage: p, i and d terms registered
// depends on pidslew_pkg
`default_nettype none

module pidslew_mul #(
    parameter int POSITION_WIDTH = pidslew_pkg::POSITION_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire pidslew_pkg::cfg_t                cfg_regs,
    input  wire logic                             up_valid,
    output logic                                  up_ready,
    input  wire logic signed [POSITION_WIDTH:0]   stage_err,
    input  wire logic signed [31:0]               stage_sum,
    input  wire logic signed [POSITION_WIDTH+1:0] stage_delta,
    input  wire pidslew_pkg::stage_ctl_t          stage_ctl,
    output logic                                  dn_valid,
    input  wire logic                             dn_ready,
    output logic signed [pidslew_pkg::GAIN_W+POSITION_WIDTH:0]   p_term,
    output logic signed [pidslew_pkg::GAIN_W+31:0]               i_term,
    output logic signed [pidslew_pkg::GAIN_W+POSITION_WIDTH+1:0] d_term,
    output pidslew_pkg::stage_ctl_t               term_ctl
);

    localparam int PPW = pidslew_pkg::GAIN_W + POSITION_WIDTH + 1;
    localparam int IPW = pidslew_pkg::GAIN_W + 32;
    localparam int DPW = pidslew_pkg::GAIN_W + POSITION_WIDTH + 2;

    logic                    v_reg;
    logic signed [PPW-1:0]   p_reg;
    logic signed [IPW-1:0]   i_reg;
    logic signed [DPW-1:0]   d_reg;
    pidslew_pkg::stage_ctl_t ctl_reg;

    logic signed [PPW-1:0] p_next;
    logic signed [IPW-1:0] i_next;
    logic signed [DPW-1:0] d_next;

    assign up_ready = !v_reg || dn_ready;

    // q8.8 gain times integer gives q.8 output units directly
    always_comb
    begin
        p_next = PPW'($signed(cfg_regs.kp_gain)) * PPW'(stage_err);
        i_next = IPW'($signed(cfg_regs.ki_gain)) * IPW'(stage_sum);
        d_next = DPW'($signed(cfg_regs.kd_gain)) * DPW'(stage_delta);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            p_reg   <= p_next;
            i_reg   <= i_next;
            d_reg   <= d_next;
            ctl_reg <= stage_ctl;
        end
    end

    assign dn_valid = v_reg;
    assign p_term   = p_reg;
    assign i_term   = i_reg;
    assign d_term   = d_reg;
    assign term_ctl = ctl_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pidslew_out.sv =====
// output stage: saturated pid sum or slew step, result register
// depends on pidslew_pkg
`default_nettype none

module pidslew_out #(
    parameter int POSITION_WIDTH = pidslew_pkg::POSITION_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pidslew_pkg::cfg_t    cfg_regs,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire logic signed [pidslew_pkg::GAIN_W+POSITION_WIDTH:0]   p_term,
    input  wire logic signed [pidslew_pkg::GAIN_W+31:0]               i_term,
    input  wire logic signed [pidslew_pkg::GAIN_W+POSITION_WIDTH+1:0] d_term,
    input  wire pidslew_pkg::stage_ctl_t                              term_ctl,
    output logic                                        dn_valid,
    input  wire logic                                   dn_ready,
    output logic signed [pidslew_pkg::POWER_W-1:0]      drive_power,
    output logic                                        is_settled
);

    localparam int DPW = pidslew_pkg::GAIN_W + POSITION_WIDTH + 2;
    localparam int IPW = pidslew_pkg::GAIN_W + 32;
    localparam int SW  = ((DPW > IPW) ? DPW : IPW) + 2;
    localparam int SLW = pidslew_pkg::POWER_W + 2;

    logic                                   v_reg;
    logic signed [pidslew_pkg::POWER_W-1:0] power_reg;
    logic                                   settled_reg;

    logic                                   adv;
    logic signed [SW-1:0]                   total;
    logic signed [SLW-1:0]                  step_s;
    logic signed [SLW-1:0]                  slewed;
    logic                                   p_pos;
    logic signed [pidslew_pkg::POWER_W-1:0] power_next;

    assign up_ready = !v_reg || dn_ready;
    assign adv      = up_valid && up_ready;

    always_comb
    begin
        total  = SW'(p_term) + SW'(i_term) + SW'(d_term);
        step_s = SLW'($signed({1'b0, cfg_regs.slew_step}));
        // zero p term steps down
        p_pos  = p_term > 0;
        slewed = p_pos ? SLW'(power_reg) + step_s : SLW'(power_reg) - step_s;
        if (term_ctl.slew_sel)
        begin
            power_next = pidslew_pkg::sat32(64'(slewed));
        end
        else
        begin
            power_next = pidslew_pkg::sat32(64'(total));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg       <= 1'b0;
            power_reg   <= '0;
            settled_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
            begin
                v_reg <= up_valid;
            end
            if (adv)
            begin
                power_reg   <= power_next;
                settled_reg <= term_ctl.settled;
            end
        end
    end

    assign dn_valid    = v_reg;
    assign drive_power = power_reg;
    assign is_settled  = settled_reg;

    // a positive slew step never lowers the power
    a_slew_up: assert property (@(posedge clk) disable iff (!rst_n)
        adv && term_ctl.slew_sel && (p_term > 0) |=> power_reg >= $past(power_reg))
        else $error("slew up lowered power");

    // power only moves on a transfer into the result register
    a_power_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(power_reg))
        else $error("power changed without a transfer");

endmodule

`default_nettype wire
